// ===== hdl/keystroke_timing_password_check_unit_assert.svh =====
// Assertion macros used by the keystroke timing password check unit.
`ifndef KEYSTROKE_TIMING_PASSWORD_CHECK_UNIT_ASSERT_SVH
`define KEYSTROKE_TIMING_PASSWORD_CHECK_UNIT_ASSERT_SVH

// The condition implies the consequence in the same cycle.
`define KTPC_ASSERT_SAME(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// The condition implies the consequence in the next cycle.
`define KTPC_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ktpc_pkg.sv =====
// Package with the types and constants of the keystroke timing password check unit.
`default_nettype none

package ktpc_pkg;

    localparam int DEF_MAX_KEYS  = 32;
    localparam int DEF_TICK_BITS = 16;

    localparam int ENTRY_W = 6;
    localparam int TOL_W   = 8;
    localparam int CODE_W  = 8;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    localparam logic [TOL_W-1:0] TOL_RESET = 8'd3;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_KEY   = 2'd1;
    localparam logic [1:0] OP_ENTER = 2'd2;

    localparam logic REG_MODE = 1'b0;
    localparam logic REG_TOL  = 1'b1;

    localparam logic MODE_ENROLL = 1'b0;
    localparam logic MODE_VERIFY = 1'b1;

    typedef struct packed {
        logic valid;
        logic enter;
        logic cmp;
        logic miss;
        logic enroll;
        logic overflow;
        logic len_ok;
    } s2_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/ktpc_cfg.sv =====
// Configuration register file of the keystroke timing password check unit.
`default_nettype none

module ktpc_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ktpc_pkg::APB_AW-1:0]   paddr,
    input  wire logic [ktpc_pkg::APB_DW-1:0]   pwdata,
    output logic      [ktpc_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    output logic                               mode,
    output logic      [ktpc_pkg::TOL_W-1:0]    tolerance
);
    import ktpc_pkg::*;

    logic             mode_reg;
    logic [TOL_W-1:0] tol_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ENROLL;
            tol_reg  <= TOL_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_MODE: mode_reg <= pwdata[0];
                REG_TOL:  tol_reg  <= pwdata[TOL_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MODE: prdata = {{(APB_DW-1){1'b0}}, mode_reg};
            REG_TOL:  prdata = {{(APB_DW-TOL_W){1'b0}}, tol_reg};
            default:  prdata = '0;
        endcase
    end

    assign mode      = mode_reg;
    assign tolerance = tol_reg;

endmodule

`default_nettype wire

// ===== hdl/ktpc_mem.sv =====
// Reference store holding the enrolled key codes and intervals.
`default_nettype none

module ktpc_mem #(
    parameter int MAX_KEYS  = ktpc_pkg::DEF_MAX_KEYS,
    parameter int TICK_BITS = ktpc_pkg::DEF_TICK_BITS,
    parameter int AW        = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1
) (
    input  wire logic                         clk,
    input  wire logic                         wr_en,
    input  wire logic [AW-1:0]                wr_addr,
    input  wire logic [ktpc_pkg::CODE_W-1:0]  wr_char,
    input  wire logic [TICK_BITS-1:0]         wr_interval,
    input  wire logic                         rd_en,
    input  wire logic [AW-1:0]                rd_addr,
    output logic      [ktpc_pkg::CODE_W-1:0]  rd_char,
    output logic      [TICK_BITS-1:0]         rd_interval
);
    import ktpc_pkg::*;

    logic [CODE_W+TICK_BITS-1:0] mem [MAX_KEYS];
    logic [CODE_W+TICK_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_char, wr_interval};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_char     = rd_data_reg[CODE_W+TICK_BITS-1:TICK_BITS];
    assign rd_interval = rd_data_reg[TICK_BITS-1:0];

endmodule

`default_nettype wire

// ===== hdl/ktpc_front.sv =====
// Front stage: tick counter, key index, store access and the compare pipeline register.
`default_nettype none

module ktpc_front #(
    parameter int MAX_KEYS  = ktpc_pkg::DEF_MAX_KEYS,
    parameter int TICK_BITS = ktpc_pkg::DEF_TICK_BITS,
    parameter int AW        = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic                          advance,
    input  wire logic [1:0]                    op,
    input  wire logic [ktpc_pkg::CODE_W-1:0]   key_code,
    input  wire logic                          mode,
    output logic                               wr_en,
    output logic      [AW-1:0]                 wr_addr,
    output logic      [TICK_BITS-1:0]          wr_interval,
    output logic                               rd_en,
    output logic      [AW-1:0]                 rd_addr,
    output ktpc_pkg::s2_ctrl_t                 pipe,
    output logic      [ktpc_pkg::CODE_W-1:0]   pipe_code,
    output logic      [TICK_BITS-1:0]          pipe_interval,
    output logic      [ktpc_pkg::ENTRY_W-1:0]  pipe_count
);
    import ktpc_pkg::*;

    localparam int KW = $clog2(MAX_KEYS + 1);
    localparam logic [KW-1:0]        KEYS_LIMIT = KW'(MAX_KEYS);
    localparam logic [TICK_BITS-1:0] TICK_MAX   = '1;

    logic [TICK_BITS-1:0] tick_reg, tick_next;
    logic [KW-1:0]        key_index_reg, key_index_next;
    logic [KW-1:0]        ref_length_reg, ref_length_next;
    logic                 overflow_reg, overflow_next;
    s2_ctrl_t             pipe_reg, pipe_next;

    logic                 is_tick, is_key, is_enter, full;
    logic [KW+ENTRY_W-1:0] count_ext;

    assign is_tick  = accept && (op == OP_TICK);
    assign is_key   = accept && (op == OP_KEY) && (key_code != '0);
    assign is_enter = accept && (op == OP_ENTER);
    assign full     = (key_index_reg >= KEYS_LIMIT);

    assign count_ext = {{ENTRY_W{1'b0}}, key_index_reg};

    assign wr_en       = is_key && !full && (mode == MODE_ENROLL);
    assign wr_addr     = key_index_reg[AW-1:0];
    assign wr_interval = tick_reg;
    assign rd_en       = is_key && !full && (mode == MODE_VERIFY);
    assign rd_addr     = key_index_reg[AW-1:0];

    always_comb
    begin
        tick_next       = tick_reg;
        key_index_next  = key_index_reg;
        ref_length_next = ref_length_reg;
        overflow_next   = overflow_reg;
        pipe_next       = '0;
        priority if (is_tick)
        begin
            if (tick_reg != TICK_MAX)
            begin
                tick_next = tick_reg + 1'b1;
            end
        end
        else if (is_key)
        begin
            tick_next = '0;
            if (full)
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                key_index_next = key_index_reg + 1'b1;
                if (mode == MODE_VERIFY)
                begin
                    pipe_next.valid = 1'b1;
                    pipe_next.cmp   = (key_index_reg < ref_length_reg);
                    pipe_next.miss  = (key_index_reg >= ref_length_reg);
                end
            end
        end
        else if (is_enter)
        begin
            tick_next          = '0;
            key_index_next     = '0;
            overflow_next      = 1'b0;
            pipe_next.valid    = 1'b1;
            pipe_next.enter    = 1'b1;
            pipe_next.enroll   = (mode == MODE_ENROLL);
            pipe_next.overflow = overflow_reg;
            pipe_next.len_ok   = (key_index_reg == ref_length_reg);
            if (mode == MODE_ENROLL)
            begin
                ref_length_next = key_index_reg;
            end
        end
        else
        begin
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg       <= '0;
            key_index_reg  <= '0;
            ref_length_reg <= '0;
            overflow_reg   <= 1'b0;
            pipe_reg       <= '0;
        end
        else
        begin
            tick_reg       <= tick_next;
            key_index_reg  <= key_index_next;
            ref_length_reg <= ref_length_next;
            overflow_reg   <= overflow_next;
            if (advance)
            begin
                pipe_reg <= pipe_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pipe_code     <= key_code;
            pipe_interval <= tick_reg;
            pipe_count    <= count_ext[ENTRY_W-1:0];
        end
    end

    assign pipe = pipe_reg;

endmodule

`default_nettype wire

// ===== hdl/ktpc_check.sv =====
// Check stage: compares a verify key with its reference entry and forms the enter result.
`default_nettype none

module ktpc_check #(
    parameter int TICK_BITS = ktpc_pkg::DEF_TICK_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ktpc_pkg::s2_ctrl_t            pipe,
    input  wire logic [ktpc_pkg::CODE_W-1:0]   pipe_code,
    input  wire logic [TICK_BITS-1:0]          pipe_interval,
    input  wire logic [ktpc_pkg::ENTRY_W-1:0]  pipe_count,
    input  wire logic [ktpc_pkg::CODE_W-1:0]   ref_char,
    input  wire logic [TICK_BITS-1:0]          ref_interval,
    input  wire logic [ktpc_pkg::TOL_W-1:0]    tolerance,
    output logic                               advance,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               match,
    output logic      [ktpc_pkg::ENTRY_W-1:0]  entry_count,
    output logic                               overflow
);
    import ktpc_pkg::*;

    logic                  mismatch_reg, mismatch_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  match_reg;
    logic [ENTRY_W-1:0]    count_reg;
    logic                  overflow_reg;
    logic                  load;
    logic                  key_bad;
    logic [TICK_BITS-1:0]  diff;

    assign advance = !(pipe.valid && pipe.enter && out_valid_reg && !out_ready);
    assign load    = pipe.valid && pipe.enter && advance;

    assign diff    = (ref_interval > pipe_interval) ? (ref_interval - pipe_interval)
                                                    : (pipe_interval - ref_interval);
    assign key_bad = pipe.miss || (pipe.cmp && ((ref_char != pipe_code) ||
                     ({{TOL_W{1'b0}}, diff} > {{TICK_BITS{1'b0}}, tolerance})));

    always_comb
    begin
        mismatch_next = mismatch_reg;
        if (pipe.valid && advance)
        begin
            if (pipe.enter)
            begin
                mismatch_next = 1'b0;
            end
            else if (key_bad)
            begin
                mismatch_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mismatch_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mismatch_reg  <= mismatch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            match_reg    <= !pipe.enroll && !mismatch_reg && !pipe.overflow && pipe.len_ok;
            count_reg    <= pipe_count;
            overflow_reg <= pipe.overflow;
        end
    end

    assign out_valid   = out_valid_reg;
    assign match       = match_reg;
    assign entry_count = count_reg;
    assign overflow    = overflow_reg;

`include "keystroke_timing_password_check_unit_assert.svh"

    `KTPC_ASSERT_NEXT(a_enter_clears_mismatch, load, !mismatch_reg, "mismatch not cleared by enter")
    `KTPC_ASSERT_NEXT(a_enroll_no_match, load && pipe.enroll, !match_reg, "match reported in enroll")
    `KTPC_ASSERT_NEXT(a_result_loaded, load, out_valid_reg, "enter result was not registered")
    `KTPC_ASSERT_SAME(a_match_no_overflow, out_valid_reg && match_reg, !overflow_reg, "match with overflow")

endmodule

`default_nettype wire

// ===== hdl/keystroke_timing_password_check_unit.sv =====
// Top level of the keystroke timing password check unit.
// The unit takes one request (tick, key or enter) in every cycle unless the input
// stalls. A key reads or writes the reference store at its index in the cycle
// it is accepted; the store's read is registered, so the character and interval
// compare follows in the next cycle. An enter request passes the front stage's
// pipeline register, and its result is then registered in the check stage.
// The input stalls only while a result waits on the output and the next enter has
// reached the compare stage. Configuration registers: mode at 0x0, tolerance at 0x4.
`default_nettype none

module keystroke_timing_password_check_unit #(
    parameter int MAX_KEYS  = ktpc_pkg::DEF_MAX_KEYS,
    parameter int TICK_BITS = ktpc_pkg::DEF_TICK_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ktpc_pkg::APB_AW-1:0]   paddr,
    input  wire logic [ktpc_pkg::APB_DW-1:0]   pwdata,
    output logic      [ktpc_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    op,
    input  wire logic [ktpc_pkg::CODE_W-1:0]   key_code,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               match,
    output logic      [ktpc_pkg::ENTRY_W-1:0]  entry_count,
    output logic                               overflow
);
    import ktpc_pkg::*;

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

    logic                  mode;
    logic [TOL_W-1:0]      tolerance;
    logic                  accept, advance;
    logic                  wr_en, rd_en;
    logic [AW-1:0]         wr_addr, rd_addr;
    logic [TICK_BITS-1:0]  wr_interval, rd_interval, pipe_interval;
    logic [CODE_W-1:0]     rd_char, pipe_code;
    logic [ENTRY_W-1:0]    pipe_count;
    s2_ctrl_t              pipe;

    assign in_ready = advance;
    assign accept   = in_valid && advance;

    ktpc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .mode      (mode),
        .tolerance (tolerance)
    );

    ktpc_mem #(
        .MAX_KEYS  (MAX_KEYS),
        .TICK_BITS (TICK_BITS),
        .AW        (AW)
    ) u_mem (
        .clk         (clk),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_char     (key_code),
        .wr_interval (wr_interval),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_char     (rd_char),
        .rd_interval (rd_interval)
    );

    ktpc_front #(
        .MAX_KEYS  (MAX_KEYS),
        .TICK_BITS (TICK_BITS),
        .AW        (AW)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .advance       (advance),
        .op            (op),
        .key_code      (key_code),
        .mode          (mode),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_interval   (wr_interval),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .pipe          (pipe),
        .pipe_code     (pipe_code),
        .pipe_interval (pipe_interval),
        .pipe_count    (pipe_count)
    );

    ktpc_check #(
        .TICK_BITS (TICK_BITS)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .pipe          (pipe),
        .pipe_code     (pipe_code),
        .pipe_interval (pipe_interval),
        .pipe_count    (pipe_count),
        .ref_char      (rd_char),
        .ref_interval  (rd_interval),
        .tolerance     (tolerance),
        .advance       (advance),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .match         (match),
        .entry_count   (entry_count),
        .overflow      (overflow)
    );

endmodule

`default_nettype wire
